/* rtl/radix_digit_converter_core_macros.svh */
// ----------------------------------------------------------------------------
// radix digit converter assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define RDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdc assertion failed");

// next-cycle implication
`define RDC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdc assertion failed");

`endif

/* rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// shared types, constants and helpers of the radix digit converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int VALUE_BITS_DEF  = 32;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int DIGIT_W         = 6;
  localparam int REM_W           = DIGIT_W + 1;
  localparam int PADDR_W         = 2;
  localparam int PDATA_W         = 32;

  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [PADDR_W-1:0] ADDR_RADIX  = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GO,
    ST_DIV,
    ST_POP_RD,
    ST_POP_LD,
    ST_OUT
  } rdc_state_t;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  function automatic logic [DIGIT_W-1:0] sat_radix(input logic [DIGIT_W-1:0] r);
    logic [DIGIT_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

endpackage

/* rtl/rdc_ram.sv */
// ----------------------------------------------------------------------------
// rdc_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rdc_div.sv */
// ----------------------------------------------------------------------------
// rdc_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_div
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIGIT_W-1:0]    divisor,
  output div_stat_t             stat,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [DIGIT_W-1:0]    div_r, div_nxt;
  logic [REM_W-1:0]      rem_sh;
  logic                  ge;

  always_comb begin
    rem_sh   = {rem_r[DIGIT_W-1:0], quo_r[VALUE_BITS-1]};
    ge       = (rem_sh >= {1'b0, div_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_BITS - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
      quo_nxt = {quo_r[VALUE_BITS-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign stat.done      = done_r;
  assign stat.quot_zero = (quo_r == '0);
  assign quotient       = quo_r;
  assign remainder      = rem_r[DIGIT_W-1:0];

endmodule

/* rtl/radix_digit_converter_core.sv */
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// converts an unsigned value to digits of the configured radix, msd first
//
//   channel  signals                          role
//   in       in_valid in_ready in_value       value to convert
//   out      out_valid out_ready out_digit    one digit per item, last flagged
//            out_last_digit
//   cfg      psel penable pwrite paddr ...    radix register at offset 0
//
// each digit of a value is one pass of the bit-serial divider, one quotient
// bit a cycle; after the last pass the digits are popped from the stack ram,
// each going through the pop_rd, pop_ld and out states
// a zero value gives no items and the core stays in idle
// output stalls hold the current digit; no new value is taken until the last
// digit is delivered; synchronous reset needs no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter_core
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIGIT_W-1:0]    out_digit,
  output logic                  out_last_digit,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  rdc_state_t            state_r, state_nxt;
  logic [DIGIT_W-1:0]    radix_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [VALUE_BITS-1:0] qwork_r, qwork_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0]    out_digit_r, out_digit_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  div_start;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DIGIT_W-1:0]    ram_rdata;
  logic [CW-1:0]         count_m1;
  logic                  in_acc;
  logic                  stack_full;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RADIX) ? PDATA_W'(radix_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_RADIX)) begin
      radix_r <= pwdata[DIGIT_W-1:0];
    end
  end

  assign in_acc     = in_valid && in_ready;
  assign count_m1   = count_r - CW'(1);
  assign stack_full = (count_r == CW'(STACK_DEPTH - 1));

  rdc_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (qwork_r),
    .divisor  (sat_radix(radix_r)),
    .stat     (div_stat),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  rdc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(div_rem),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_value != '0)) begin
          state_nxt = ST_GO;
        end
      end
      ST_GO: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = (div_stat.quot_zero || stack_full) ? ST_POP_RD : ST_GO;
        end
      end
      ST_POP_RD: begin
        state_nxt = ST_POP_LD;
      end
      ST_POP_LD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = (count_r == '0) ? ST_IDLE : ST_POP_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready      = 1'b0;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = count_r[AW-1:0];
    count_nxt     = count_r;
    qwork_nxt     = qwork_r;
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        count_nxt = '0;
        if (in_acc) begin
          qwork_nxt = in_value;
        end
      end
      ST_GO: begin
        div_start = 1'b1;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          qwork_nxt = div_quot;
        end
      end
      ST_POP_RD: begin
        ram_addr  = count_m1[AW-1:0];
        count_nxt = count_m1;
      end
      ST_POP_LD: begin
        out_valid_nxt = 1'b1;
        out_digit_nxt = ram_rdata;
        out_last_nxt  = (count_r == '0);
      end
      ST_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qwork_r     <= qwork_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_last_digit = out_last_r;

endmodule

/* rtl/rdc_checker.sv */
// ----------------------------------------------------------------------------
// rdc_checker
// port-level checks of the radix digit converter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "radix_digit_converter_core_macros.svh"

module rdc_checker
  import rdc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DIGIT_W-1:0] out_digit,
  input logic               out_last_digit
);

  // stalled item holds
  `RDC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(out_digit) && $stable(out_last_digit))

  // one value at a time
  `RDC_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)

  // digits stay inside the widest radix
  `RDC_ASSERT_NOW(a_digit_range, out_valid, out_digit <= RADIX_MAX - 6'd1)

  // a run goes on until its last digit is taken
  `RDC_ASSERT_NXT(a_run_open, out_valid && out_ready && !out_last_digit, !in_ready)

  // an accepted value gives no item in the next cycle
  `RDC_ASSERT_NXT(a_acc_gap, in_valid && in_ready, !out_valid)

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (.*);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// radix digit converter testbench
// drives values through the converter at many radix settings, including the
// saturated ones, and checks every digit and its last flag against a digit
// predictor kept in step with the radix register; random idling on both
// channels, two long output hold-offs, and a calm final phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rdc_pkg::*;

  localparam int VALUE_BITS       = VALUE_BITS_DEF;
  localparam int STACK_LIMIT      = STACK_DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 25;
  localparam int PHASE_COUNT      = 14;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD        = 500;
  localparam int WATCHDOG_LIMIT   = 8000;

  localparam logic [DIGIT_W-1:0] FIXED_RADIX [9] = '{
    6'd0, 6'd1, 6'd63, 6'd37, 6'd16, 6'd3, 6'd7, 6'd2, 6'd36
  };
  localparam logic [VALUE_BITS-1:0] DECIMAL_VALUES [15] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'd1000000000, 32'd4000000000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd12345, 32'd0
  };

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_last;
  } digit_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DIGIT_W-1:0]    out_digit;
  logic                  out_last_digit;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  logic [VALUE_BITS-1:0] value_backlog [$];
  digit_rec_t            pending_digits [$];
  digit_rec_t            head_rec;
  logic [DIGIT_W-1:0]    radix_shadow = RADIX_RESET;
  int                    fault_count = 0;
  bit                    send_idle_en = 1'b1;
  bit                    recv_idle_en = 1'b1;
  int                    send_gap = 0;
  int                    recv_gap = 0;
  int                    hold_left = 0;
  int                    hold_req = 0;
  int                    hold_ack = 0;
  int                    quiet_cycles = 0;

  radix_digit_converter_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit     (out_digit),
    .out_last_digit(out_last_digit),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // divisor actually used for a register setting
  function automatic int unsigned eff_base(input logic [DIGIT_W-1:0] r);
    if (r < 2) return 2;
    if (r > 36) return 36;
    return 32'(r);
  endfunction

  function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                         input logic [DIGIT_W-1:0] r);
    logic [DIGIT_W-1:0]    stack [STACK_LIMIT];
    logic [VALUE_BITS-1:0] quot;
    int unsigned           base;
    int                    depth;
    digit_rec_t            rec;
    base = eff_base(r);
    quot = v;
    depth = 0;
    while (quot != 0 && depth < STACK_LIMIT) begin
      stack[depth] = DIGIT_W'(quot % base);
      depth++;
      quot = VALUE_BITS'(quot / base);
    end
    for (int i = depth - 1; i >= 0; i--) begin
      rec.digit = stack[i];
      rec.is_last = (i == 0);
      pending_digits.push_back(rec);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned base);
    logic [63:0] pw;
    int unsigned k;
    k = $urandom_range(0, 31);
    pw = 64'd1;
    for (int j = 0; j < k && pw * base <= 64'hFFFF_FFFF; j++) begin
      pw = pw * base;
    end
    case ($urandom_range(0, 6))
      0, 1: return $urandom();
      2: return $urandom() >> $urandom_range(1, 31);
      3: return $urandom_range(1, base * base);
      4: return pw[VALUE_BITS-1:0];
      5: return pw[VALUE_BITS-1:0] - 1;
      default: return ($urandom_range(0, 3) == 0) ? '0 : ~32'($urandom_range(0, 15));
    endcase
  endfunction

  // wait until every value is taken and every digit is back, then let the core drain
  task automatic settle();
    do @(negedge clk); while (value_backlog.size() != 0 || in_valid ||
                              pending_digits.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_radix(input logic [DIGIT_W-1:0] r);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[DIGIT_W-1:0] = r;
    settle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_RADIX;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    send_idle_en = ($urandom_range(0, 3) != 0);
    recv_idle_en = ($urandom_range(0, 3) != 0);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (value_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_idle_en && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_value <= value_backlog.pop_front();
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      hold_ack <= hold_req;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
      recv_gap <= $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and digit check
  always @(posedge clk) begin
    if (!rst_n) begin
      radix_shadow <= RADIX_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_RADIX) begin
        radix_shadow <= pwdata[DIGIT_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected digit: expected none, actual digit %0d last %0b",
                   $time, out_digit, out_last_digit);
          fault_count++;
        end else begin
          head_rec = pending_digits.pop_front();
          if (out_digit !== head_rec.digit) begin
            $display("%0t: digit: expected %0d, actual %0d",
                     $time, head_rec.digit, out_digit);
            fault_count++;
          end
          if (out_last_digit !== head_rec.is_last) begin
            $display("%0t: last_digit: expected %0b, actual %0b",
                     $time, head_rec.is_last, out_last_digit);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_digits(in_value, radix_shadow);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [DIGIT_W-1:0] r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset radix first, then both ends of the legal range
    foreach (DECIMAL_VALUES[i]) value_backlog.push_back(DECIMAL_VALUES[i]);
    set_radix(6'd2);
    value_backlog.push_back(32'hFFFF_FFFF);
    value_backlog.push_back(32'h8000_0000);
    value_backlog.push_back(32'd1);
    value_backlog.push_back(32'd2);
    set_radix(6'd36);
    value_backlog.push_back(32'hFFFF_FFFF);
    value_backlog.push_back(32'd35);
    value_backlog.push_back(32'd36);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      r = (p < 9) ? FIXED_RADIX[p] : 6'($urandom_range(0, 63));
      set_radix(r);
      if (p == PHASE_COUNT - 1) begin
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
      end
      repeat (RANDOM_PER_PHASE) value_backlog.push_back(pick_value(eff_base(r)));
      // long output hold-off while the backlog is full
      if (p == 4 || p == 7) hold_req++;
    end

    settle();
    if (fault_count == 0 && pending_digits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
